FILE: rtl/wsc_pkg.sv
package wsc_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;

   localparam int DATA_W   = 24;
   localparam int WEIGHT_W = 16;
   localparam int ENERGY_W = 64;
   localparam int CFG_W    = 11;
   localparam int INDEX_W  = 10;
   localparam int COH_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MUTE_END_SAMPLE = 2'd2;

   localparam logic REQ_ACCUMULATE = 1'b0;
   localparam logic REQ_QUERY      = 1'b1;

   // Per-lane store and window-sum controls, driven by the top-level sequencer.
   typedef struct packed {
      logic we;
      logic clr;
      logic first;
      logic sum_clr;
      logic sum_en;
   } lane_ctl_type;

   function automatic logic [ENERGY_W-1:0] sat_add64(input logic [ENERGY_W-1:0] a,
                                                     input logic [ENERGY_W-1:0] b);
      logic [ENERGY_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ENERGY_W] ? '1 : s[ENERGY_W-1:0];
   endfunction

   // Magnitude of a 25-bit signed value; never exceeds 2^24-1 here.
   function automatic logic [DATA_W-1:0] abs_mag(input logic signed [DATA_W:0] v);
      logic [DATA_W:0] a;
      a = v[DATA_W] ? (DATA_W+1)'(-v) : v;
      return a[DATA_W-1:0];
   endfunction

endpackage

FILE: rtl/wsc_coh.sv
// Coherence unit: 1 - sqrt(r/d) in Q0.16, by a bit-serial divide
// followed by a bit-serial integer square root.
module wsc_coh
   import wsc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [ENERGY_W-1:0] resid,
   input  logic [ENERGY_W-1:0] data,
   output logic                done,
   output logic [COH_W-1:0]    result
);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_DIV  = 3'b010,
      CS_SQRT = 3'b100
   } coh_state_type;

   coh_state_type       state_ff, state_in;
   logic [ENERGY_W-1:0] rem_ff, rem_in;
   logic [ENERGY_W-1:0] den_ff, den_in;
   logic [32:0]         q_ff, q_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [16:0]         k_ff, k_in;
   logic                done_ff, done_in;
   logic [COH_W-1:0]    res_ff, res_in;

   logic [ENERGY_W:0]   shifted;
   logic                take;
   logic [16:0]         cand;
   logic [33:0]         cand_sq;
   logic [16:0]         k_next;

   assign shifted = {rem_ff, 1'b0};
   assign take    = shifted >= {1'b0, den_ff};
   assign cand    = k_ff | (17'd1 << cnt_ff);
   assign cand_sq = 34'(cand) * 34'(cand);
   assign k_next  = (cand_sq <= {1'b0, q_ff}) ? cand : k_ff;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      done_in  = done_ff;
      res_in   = res_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               if (resid == '0 || data == '0 || resid > data) begin
                  res_in  = '0;
                  done_in = 1'b1;
               end else begin
                  done_in  = 1'b0;
                  den_in   = data;
                  q_in     = {32'd0, resid == data};
                  rem_in   = (resid == data) ? '0 : resid;
                  cnt_in   = 5'd31;
                  state_in = CS_DIV;
               end
            end
         end
         CS_DIV: begin
            rem_in = take ? ENERGY_W'(shifted - {1'b0, den_ff}) : shifted[ENERGY_W-1:0];
            q_in   = {q_ff[31:0], take};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               k_in     = '0;
               cnt_in   = 5'd16;
               state_in = CS_SQRT;
            end
         end
         CS_SQRT: begin
            k_in   = k_next;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               res_in   = (k_next == '0) ? '1 : COH_W'(17'h10000 - k_next);
               done_in  = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      k_ff   <= k_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

FILE: rtl/wsc_lane.sv
// One component lane: energy pipeline, data and residual stores, window sums.
module wsc_lane
   import wsc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   localparam int AW = $clog2(MAX_SAMPLES)
)(
   input  logic                       clock,
   input  lane_ctl_type               ctl,
   input  logic [AW-1:0]              addr,
   input  logic signed [DATA_W-1:0]   data,
   input  logic signed [DATA_W-1:0]   stack,
   input  logic [WEIGHT_W-1:0]        weight,
   output logic [ENERGY_W-1:0]        rd_data,
   output logic [ENERGY_W-1:0]        rd_resid,
   output logic [ENERGY_W-1:0]        sum_data,
   output logic [ENERGY_W-1:0]        sum_resid
);

   logic [ENERGY_W-1:0] dmem [MAX_SAMPLES];
   logic [ENERGY_W-1:0] rmem [MAX_SAMPLES];

   logic signed [DATA_W:0] diff;
   logic [DATA_W-1:0]      mag_d, mag_r;
   logic [39:0]            prod_d, prod_r;
   logic [31:0]            wd_ff, wr_ff;
   logic [ENERGY_W-1:0]    sq_d_ff, sq_r_ff;
   logic [ENERGY_W-1:0]    rd_d_ff, rd_r_ff;
   logic [ENERGY_W-1:0]    wdat_d, wdat_r;
   logic [ENERGY_W-1:0]    sum_d_ff, sum_r_ff;

   assign diff   = {data[DATA_W-1], data} - {stack[DATA_W-1], stack};
   assign mag_d  = abs_mag({data[DATA_W-1], data});
   assign mag_r  = abs_mag(diff);
   assign prod_d = 40'(mag_d) * 40'(weight);
   assign prod_r = 40'(mag_r) * 40'(weight);

   always_ff @(posedge clock) begin
      wd_ff   <= prod_d[39:8];
      wr_ff   <= prod_r[39:8];
      sq_d_ff <= 64'(wd_ff) * 64'(wd_ff);
      sq_r_ff <= 64'(wr_ff) * 64'(wr_ff);
   end

   assign wdat_d = ctl.clr ? '0 : (ctl.first ? sq_d_ff : sat_add64(rd_d_ff, sq_d_ff));
   assign wdat_r = ctl.clr ? '0 : (ctl.first ? sq_r_ff : sat_add64(rd_r_ff, sq_r_ff));

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         dmem[addr] <= wdat_d;
         rmem[addr] <= wdat_r;
      end
      rd_d_ff <= dmem[addr];
      rd_r_ff <= rmem[addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.sum_clr) begin
         sum_d_ff <= '0;
         sum_r_ff <= '0;
      end else if (ctl.sum_en) begin
         sum_d_ff <= sat_add64(sum_d_ff, rd_d_ff);
         sum_r_ff <= sat_add64(sum_r_ff, rd_r_ff);
      end
   end

   assign rd_data   = rd_d_ff;
   assign rd_resid  = rd_r_ff;
   assign sum_data  = sum_d_ff;
   assign sum_resid = sum_r_ff;

endmodule

FILE: rtl/weighted_stack_coherence.sv
// Weighted stack coherence. Accumulate beats add weighted data and residual
// energies of one three-component sample into per-sample stores (first_trace
// overwrites); query beats sum the stores over a clipped window and return
// 1 - sqrt(residual/data) per component and in total, as one rsp_valid
// strobe. The receiver cannot stall: each result is present for exactly one
// cycle. After reset the block is busy while a clearing pass zeroes the
// stores; configuration writes are taken meanwhile. An accumulate keeps busy
// high through multiply, square, then the read-modify-write of the stores. A
// query with a nonempty window keeps busy high through one store read per
// window sample, a drain state, a start state, then a 32-step divide and a
// 17-step square root, until the coherence units are seen to finish. When all
// four sums give a zero coherence without dividing, the divide and square
// root are skipped. Muted, empty and ignored requests leave busy low.
module weighted_stack_coherence
   import wsc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
)(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_type,
   input  logic [INDEX_W-1:0]         req_sample_index,
   input  logic                       req_first_trace,
   input  logic signed [DATA_W-1:0]   req_data_x,
   input  logic signed [DATA_W-1:0]   req_data_y,
   input  logic signed [DATA_W-1:0]   req_data_z,
   input  logic signed [DATA_W-1:0]   req_stack_x,
   input  logic signed [DATA_W-1:0]   req_stack_y,
   input  logic signed [DATA_W-1:0]   req_stack_z,
   input  logic [WEIGHT_W-1:0]        req_weight,
   output logic                       rsp_valid,
   output logic [COH_W-1:0]           rsp_coherence_x,
   output logic [COH_W-1:0]           rsp_coherence_y,
   output logic [COH_W-1:0]           rsp_coherence_z,
   output logic [COH_W-1:0]           rsp_coherence_total,
   output logic [CFG_W-1:0]           rsp_samples_used,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata
);

   localparam int AW = $clog2(MAX_SAMPLES);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_CLEAR   = 9'b000000010,
      ST_ACC1    = 9'b000000100,
      ST_ACC2    = 9'b000001000,
      ST_ACC3    = 9'b000010000,
      ST_QRY     = 9'b000100000,
      ST_QDRAIN  = 9'b001000000,
      ST_COHGO   = 9'b010000000,
      ST_COHWAIT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [CFG_W-1:0] sample_count_ff, window_length_ff, mute_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= CFG_W'(1024);
         window_length_ff <= CFG_W'(16);
         mute_end_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SAMPLE_COUNT:    sample_count_ff  <= csr_wdata;
            REG_WINDOW_LENGTH:   window_length_ff <= csr_wdata;
            REG_MUTE_END_SAMPLE: mute_end_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Samples in use, capped at the store depth.
   logic [CFG_W-1:0] active_n;
   assign active_n = (int'(sample_count_ff) < MAX_SAMPLES) ? sample_count_ff
                                                            : CFG_W'(MAX_SAMPLES);

   // Window length of a query beat, decided at acceptance.
   logic             accept;
   logic             in_range;
   logic             muted;
   logic [CFG_W-1:0] avail;
   logic [CFG_W-1:0] q_count;

   assign accept   = start && !busy;
   assign in_range = {1'b0, req_sample_index} < active_n;
   assign muted    = {1'b0, req_sample_index} < mute_end_ff;
   assign avail    = active_n - {1'b0, req_sample_index};
   assign q_count  = (muted || !in_range) ? '0
                   : ((window_length_ff < avail) ? window_length_ff : avail);

   // Captured beat.
   logic [INDEX_W-1:0]       idx_ff;
   logic                     first_ff;
   logic signed [DATA_W-1:0] dx_ff, dy_ff, dz_ff, sx_ff, sy_ff, sz_ff;
   logic [WEIGHT_W-1:0]      w_ff;
   logic [CFG_W-1:0]         used_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff   <= req_sample_index;
         first_ff <= req_first_trace;
         dx_ff    <= req_data_x;
         dy_ff    <= req_data_y;
         dz_ff    <= req_data_z;
         sx_ff    <= req_stack_x;
         sy_ff    <= req_stack_y;
         sz_ff    <= req_stack_z;
         w_ff     <= req_weight;
         used_ff  <= q_count;
      end
   end

   // Clear pointer, window walk address and remaining count.
   logic [AW-1:0]    clr_ff, clr_in;
   logic [CFG_W-1:0] walk_ff, walk_in;
   logic [CFG_W-1:0] left_ff, left_in;
   logic             qv_ff;

   // Coherence units and lanes.
   lane_ctl_type        ctl;
   logic [AW-1:0]       addr;
   logic                coh_start;
   logic [3:0]          coh_done;
   logic [COH_W-1:0]    coh_res [4];
   logic [ENERGY_W-1:0] rd_d [3];
   logic [ENERGY_W-1:0] rd_r [3];
   logic [ENERGY_W-1:0] sum_d [3];
   logic [ENERGY_W-1:0] sum_r [3];
   logic [ENERGY_W-1:0] tot_d_ff, tot_r_ff;
   logic [ENERGY_W+1:0] tsum_d, tsum_r;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COH_W-1:0]    cx_ff, cy_ff, cz_ff, ct_ff;
   logic [CFG_W-1:0]    su_ff;
   logic                load_coh, load_zero;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      walk_in   = walk_ff;
      left_in   = left_ff;
      ctl       = '0;
      addr      = AW'(walk_ff);
      coh_start = 1'b0;
      load_coh  = 1'b0;
      load_zero = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_ACCUMULATE) begin
                  if (in_range) begin
                     state_in = ST_ACC1;
                  end
               end else begin
                  ctl.sum_clr = 1'b1;
                  walk_in     = {1'b0, req_sample_index};
                  left_in     = q_count;
                  if (q_count == '0) begin
                     load_zero = 1'b1;
                  end else begin
                     state_in = ST_QRY;
                  end
               end
            end
         end
         ST_CLEAR: begin
            addr    = clr_ff;
            ctl.we  = 1'b1;
            ctl.clr = 1'b1;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_SAMPLES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ACC1: begin
            addr     = AW'(idx_ff);
            state_in = ST_ACC2;
         end
         ST_ACC2: begin
            addr     = AW'(idx_ff);
            state_in = ST_ACC3;
         end
         ST_ACC3: begin
            addr      = AW'(idx_ff);
            ctl.we    = 1'b1;
            ctl.first = first_ff;
            state_in  = ST_IDLE;
         end
         ST_QRY: begin
            ctl.sum_en = qv_ff;
            walk_in    = walk_ff + CFG_W'(1);
            left_in    = left_ff - CFG_W'(1);
            if (left_ff == CFG_W'(1)) begin
               state_in = ST_QDRAIN;
            end
         end
         ST_QDRAIN: begin
            ctl.sum_en = qv_ff;
            state_in   = ST_COHGO;
         end
         ST_COHGO: begin
            coh_start = 1'b1;
            state_in  = ST_COHWAIT;
         end
         ST_COHWAIT: begin
            if (coh_done == 4'hF) begin
               load_coh = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         qv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         qv_ff    <= (state_ff == ST_QRY);
      end
      walk_ff <= walk_in;
      left_ff <= left_in;
   end

   assign busy = (state_ff != ST_IDLE);

   wsc_lane #(.MAX_SAMPLES(MAX_SAMPLES)) u_lane_x (
      .clock(clock), .ctl(ctl), .addr(addr),
      .data(dx_ff), .stack(sx_ff), .weight(w_ff),
      .rd_data(rd_d[0]), .rd_resid(rd_r[0]),
      .sum_data(sum_d[0]), .sum_resid(sum_r[0])
   );

   wsc_lane #(.MAX_SAMPLES(MAX_SAMPLES)) u_lane_y (
      .clock(clock), .ctl(ctl), .addr(addr),
      .data(dy_ff), .stack(sy_ff), .weight(w_ff),
      .rd_data(rd_d[1]), .rd_resid(rd_r[1]),
      .sum_data(sum_d[1]), .sum_resid(sum_r[1])
   );

   wsc_lane #(.MAX_SAMPLES(MAX_SAMPLES)) u_lane_z (
      .clock(clock), .ctl(ctl), .addr(addr),
      .data(dz_ff), .stack(sz_ff), .weight(w_ff),
      .rd_data(rd_d[2]), .rd_resid(rd_r[2]),
      .sum_data(sum_d[2]), .sum_resid(sum_r[2])
   );

   // Merge stage: the totals take all three lanes' reads each sum_en cycle.
   // Saturating adds of nonnegative terms give the same result in any order.
   assign tsum_d = 66'(tot_d_ff) + 66'(rd_d[0]) + 66'(rd_d[1]) + 66'(rd_d[2]);
   assign tsum_r = 66'(tot_r_ff) + 66'(rd_r[0]) + 66'(rd_r[1]) + 66'(rd_r[2]);

   always_ff @(posedge clock) begin
      if (ctl.sum_clr) begin
         tot_d_ff <= '0;
         tot_r_ff <= '0;
      end else if (ctl.sum_en) begin
         tot_d_ff <= (tsum_d[ENERGY_W+1:ENERGY_W] != 2'b00) ? '1 : tsum_d[ENERGY_W-1:0];
         tot_r_ff <= (tsum_r[ENERGY_W+1:ENERGY_W] != 2'b00) ? '1 : tsum_r[ENERGY_W-1:0];
      end
   end

   wsc_coh u_coh_x (
      .clock(clock), .reset(reset), .start(coh_start),
      .resid(sum_r[0]), .data(sum_d[0]), .done(coh_done[0]), .result(coh_res[0])
   );

   wsc_coh u_coh_y (
      .clock(clock), .reset(reset), .start(coh_start),
      .resid(sum_r[1]), .data(sum_d[1]), .done(coh_done[1]), .result(coh_res[1])
   );

   wsc_coh u_coh_z (
      .clock(clock), .reset(reset), .start(coh_start),
      .resid(sum_r[2]), .data(sum_d[2]), .done(coh_done[2]), .result(coh_res[2])
   );

   wsc_coh u_coh_t (
      .clock(clock), .reset(reset), .start(coh_start),
      .resid(tot_r_ff), .data(tot_d_ff), .done(coh_done[3]), .result(coh_res[3])
   );

   // Result register: one strobe per query beat.
   assign rsp_valid_in = load_coh || load_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_zero) begin
         cx_ff <= '0;
         cy_ff <= '0;
         cz_ff <= '0;
         ct_ff <= '0;
         su_ff <= '0;
      end else if (load_coh) begin
         cx_ff <= coh_res[0];
         cy_ff <= coh_res[1];
         cz_ff <= coh_res[2];
         ct_ff <= coh_res[3];
         su_ff <= used_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coherence_x     = cx_ff;
   assign rsp_coherence_y     = cy_ff;
   assign rsp_coherence_z     = cz_ff;
   assign rsp_coherence_total = ct_ff;
   assign rsp_samples_used    = su_ff;

endmodule

FILE: tb/sv/tb.sv
module tb;
   import wsc_pkg::*;

   // Index 3 is not a register; writes to it must be dropped by the block.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int NSAMP = MAX_SAMPLES_DEF;

   // One request beat, as the sender presents it.
   typedef struct {
      logic                     kind;
      logic [INDEX_W-1:0]       index;
      logic                     first;
      logic signed [DATA_W-1:0] dat [3];
      logic signed [DATA_W-1:0] stk [3];
      logic [WEIGHT_W-1:0]      weight;
   } stack_beat_type;

   // One coherence result as the block should report it.
   typedef struct {
      logic [COH_W-1:0] coh [4];
      logic [CFG_W-1:0] used;
   } coherence_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = REQ_ACCUMULATE;
   logic [INDEX_W-1:0] req_sample_index = '0;
   logic req_first_trace = 1'b0;
   logic signed [DATA_W-1:0] req_data_x = '0, req_data_y = '0, req_data_z = '0;
   logic signed [DATA_W-1:0] req_stack_x = '0, req_stack_y = '0, req_stack_z = '0;
   logic [WEIGHT_W-1:0] req_weight = '0;
   logic rsp_valid;
   logic [COH_W-1:0] rsp_coherence_x, rsp_coherence_y, rsp_coherence_z;
   logic [COH_W-1:0] rsp_coherence_total;
   logic [CFG_W-1:0] rsp_samples_used;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   weighted_stack_coherence dut (.*);

   always #4 clock = ~clock;

   // Shadow copy of the block state: energy stores and registers.
   logic [ENERGY_W-1:0] data_nrg  [3][NSAMP];
   logic [ENERGY_W-1:0] resid_nrg [3][NSAMP];
   logic [CFG_W-1:0] sample_count_reg = 11'd1024;
   logic [CFG_W-1:0] window_reg = 11'd16;
   logic [CFG_W-1:0] mute_reg = 11'd0;

   coherence_type coherence_due [$];
   int fail_count = 0;
   int beats_sent = 0;

   initial begin
      for (int c = 0; c < 3; c++)
         for (int s = 0; s < NSAMP; s++) begin
            data_nrg[c][s] = '0;
            resid_nrg[c][s] = '0;
         end
   end

   // Sums in the block clip at all ones rather than wrapping.
   function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // |v| * weight is Q39; dropping 8 bits gives Q31, whose square is the energy.
   function automatic logic [63:0] weighted_energy(logic signed [63:0] v, logic [15:0] w);
      logic [63:0] mag;
      logic [63:0] m;
      mag = (v < 0) ? -v : v;
      m = (mag * 64'(w)) >> 8;
      return m * m;
   endfunction

   // Exact floor(65536*sqrt(r/d)) by bitwise search, then one minus that.
   function automatic logic [15:0] coherence_of_sums(logic [63:0] r, logic [63:0] d);
      logic [16:0] k, cand, res;
      logic [127:0] lhs, rhs;
      if (r == 0 || d == 0 || r > d) return '0;
      k = '0;
      rhs = {64'd0, r} << 32;
      for (int b = 16; b >= 0; b--) begin
         cand = k | (17'd1 << b);
         if (cand <= 17'd65536) begin
            lhs = 128'(cand) * 128'(cand) * 128'(d);
            if (lhs <= rhs) k = cand;
         end
      end
      res = 17'd65536 - k;
      return (res > 17'd65535) ? 16'hFFFF : res[15:0];
   endfunction

   function automatic int active_count();
      return (sample_count_reg < NSAMP) ? int'(sample_count_reg) : NSAMP;
   endfunction

   // Applies one accepted beat to the shadow state and queues any result.
   task automatic apply_stack_beat(input stack_beat_type b);
      logic [63:0] rs [3], ds [3];
      logic [63:0] rt, dt, de, re;
      coherence_type e;
      int ns, cnt;
      ns = active_count();
      if (b.kind == REQ_ACCUMULATE) begin
         if (int'(b.index) < ns)
            for (int c = 0; c < 3; c++) begin
               de = weighted_energy(64'(b.dat[c]), b.weight);
               re = weighted_energy(64'(b.dat[c]) - 64'(b.stk[c]), b.weight);
               data_nrg[c][b.index] = b.first ? de : clip_add(data_nrg[c][b.index], de);
               resid_nrg[c][b.index] = b.first ? re : clip_add(resid_nrg[c][b.index], re);
            end
         return;
      end
      for (int c = 0; c < 4; c++) e.coh[c] = '0;
      e.used = '0;
      if (11'(b.index) >= mute_reg) begin
         rt = '0;
         dt = '0;
         for (int c = 0; c < 3; c++) begin
            rs[c] = '0;
            ds[c] = '0;
         end
         cnt = 0;
         for (int s = b.index; cnt < int'(window_reg) && s < ns; s++) begin
            cnt++;
            for (int c = 0; c < 3; c++) begin
               rs[c] = clip_add(rs[c], resid_nrg[c][s]);
               ds[c] = clip_add(ds[c], data_nrg[c][s]);
               rt = clip_add(rt, resid_nrg[c][s]);
               dt = clip_add(dt, data_nrg[c][s]);
            end
         end
         e.used = 11'(cnt);
         if (cnt != 0) begin
            for (int c = 0; c < 3; c++) e.coh[c] = coherence_of_sums(rs[c], ds[c]);
            e.coh[3] = coherence_of_sums(rt, dt);
         end
      end
      coherence_due.insert(coherence_due.size(), e);
   endtask

   // Presents one beat and holds it until the block takes it. On return the
   // caller is at the accepting edge and must either send or rest in this step.
   task automatic send_beat(input stack_beat_type b);
      start <= 1'b1;
      req_type <= b.kind;
      req_sample_index <= b.index;
      req_first_trace <= b.first;
      req_data_x <= b.dat[0];
      req_data_y <= b.dat[1];
      req_data_z <= b.dat[2];
      req_stack_x <= b.stk[0];
      req_stack_y <= b.stk[1];
      req_stack_z <= b.stk[2];
      req_weight <= b.weight;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_stack_beat(b);
      beats_sent++;
   endtask

   task automatic rest(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // The sender idles at random, except over one long calm stretch.
   function automatic int random_gap();
      if (beats_sent >= 700 && beats_sent < 1000) return 0;
      return ($urandom_range(99) < 17) ? int'($urandom_range(1, 4)) : 0;
   endfunction

   function automatic stack_beat_type make_beat(logic kind, int index, logic first,
                                                int dx, int dy, int dz,
                                                int sx, int sy, int sz, int w);
      stack_beat_type b;
      b.kind = kind;
      b.index = INDEX_W'(index);
      b.first = first;
      b.dat[0] = DATA_W'(dx);
      b.dat[1] = DATA_W'(dy);
      b.dat[2] = DATA_W'(dz);
      b.stk[0] = DATA_W'(sx);
      b.stk[1] = DATA_W'(sy);
      b.stk[2] = DATA_W'(sz);
      b.weight = WEIGHT_W'(w);
      return b;
   endfunction

   function automatic stack_beat_type query_at(int index);
      return make_beat(REQ_QUERY, index, 1'b0, 0, 0, 0, 0, 0, 0, 0);
   endfunction

   // Waits for all results, then lets any trailing accumulate finish.
   task automatic settle();
      start <= 1'b0;
      while (coherence_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Writes all three registers back to back, and optionally the unused index.
   task automatic set_registers(input int count, input int window, input int mute,
                                input bit stray);
      csr_we <= 1'b1;
      csr_index <= REG_SAMPLE_COUNT;
      csr_wdata <= CFG_W'(count);
      @(posedge clock);
      csr_index <= REG_WINDOW_LENGTH;
      csr_wdata <= CFG_W'(window);
      @(posedge clock);
      csr_index <= REG_MUTE_END_SAMPLE;
      csr_wdata <= CFG_W'(mute);
      @(posedge clock);
      if (stray) begin
         csr_index <= REG_UNUSED;
         csr_wdata <= '1;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
      sample_count_reg = CFG_W'(count);
      window_reg = CFG_W'(window);
      mute_reg = CFG_W'(mute);
   endtask

   // Extremes of the sample fields, saturation, residual above data, zero
   // residual, zero weight and the clipped window at the last sample under the
   // reset register values, then queries on both sides of a mute end.
   task automatic test_directed();
      send_beat(query_at(0));
      send_beat(make_beat(REQ_ACCUMULATE, 0, 1'b1, -8388608, 8388607, 0,
                          8388607, -8388608, 0, 65535));
      send_beat(make_beat(REQ_ACCUMULATE, 0, 1'b0, -8388608, 8388607, 0,
                          8388607, -8388608, 0, 65535));
      send_beat(make_beat(REQ_ACCUMULATE, 0, 1'b0, -8388608, 8388607, 1,
                          8388607, -8388608, -1, 65535));
      send_beat(make_beat(REQ_ACCUMULATE, 1, 1'b1, 12345, -777, 8388607,
                          12345, -777, 8388607, 40000));
      send_beat(make_beat(REQ_ACCUMULATE, 2, 1'b1, 1000, -2000, 3000,
                          900, -2100, 2000, 32768));
      send_beat(make_beat(REQ_ACCUMULATE, 2, 1'b0, 5000, 6000, -7000,
                          5100, 5900, -7300, 1));
      send_beat(make_beat(REQ_ACCUMULATE, 3, 1'b1, 8388607, 8388607, 8388607,
                          0, 0, 0, 0));
      send_beat(make_beat(REQ_ACCUMULATE, 1023, 1'b1, 300000, -4000000, 65536,
                          250000, -3000000, 70000, 65535));
      send_beat(query_at(0));
      send_beat(query_at(1));
      rest(3);
      send_beat(query_at(2));
      send_beat(query_at(3));
      send_beat(query_at(1023));
      send_beat(query_at(1010));
      settle();
      set_registers(1024, 16, 5, 1'b0);
      send_beat(query_at(4));
      send_beat(query_at(5));
      send_beat(query_at(0));
      settle();
   endtask

   // Register corners: no samples, zero window, masked large values, full
   // mute, the unused index, a one-sample trace and the widest window.
   task automatic test_register_extremes();
      set_registers(0, 16, 0, 1'b1);
      send_beat(make_beat(REQ_ACCUMULATE, 0, 1'b1, 1, 2, 3, 4, 5, 6, 7));
      send_beat(query_at(0));
      settle();
      set_registers(2047, 0, 0, 1'b0);
      send_beat(query_at(2));
      settle();
      set_registers(1024, 1024, 1024, 1'b1);
      send_beat(query_at(1023));
      send_beat(query_at(0));
      settle();
      set_registers(1, 1024, 0, 1'b0);
      send_beat(make_beat(REQ_ACCUMULATE, 1, 1'b1, 9, 9, 9, 0, 0, 0, 65535));
      send_beat(query_at(0));
      send_beat(query_at(1));
      settle();
      set_registers(1024, 1024, 0, 1'b0);
      send_beat(query_at(0));
      settle();
   endtask

   function automatic int random_sample();
      return int'($urandom) <<< 8 >>> 8;
   endfunction

   // One ensemble: a first-trace pass over a few samples, more traces on top,
   // then queries around them. A tenth of the beats are unrelated noise.
   task automatic run_ensemble();
      stack_beat_type b;
      int ns, base, span, traces, d, noise;
      ns = active_count();
      base = (ns > 0) ? int'($urandom_range(0, ns - 1)) : int'($urandom_range(0, 1023));
      span = int'($urandom_range(1, 8));
      traces = int'($urandom_range(1, 4));
      for (int t = 0; t < traces; t++)
         for (int s = base; s < base + span && s < NSAMP; s++) begin
            b = make_beat(REQ_ACCUMULATE, s, t == 0, 0, 0, 0, 0, 0, 0, int'($urandom));
            if ($urandom_range(9) == 0) b.weight = $urandom_range(1) ? 16'hFFFF : 16'h0;
            noise = ($urandom_range(3) == 0) ? 8388607 : 20000;
            for (int c = 0; c < 3; c++) begin
               d = random_sample();
               b.dat[c] = DATA_W'(d);
               b.stk[c] = $urandom_range(4) == 0 ? DATA_W'(random_sample())
                          : DATA_W'(d + int'($urandom_range(0, 2 * noise)) - noise);
            end
            if ($urandom_range(9) == 0) begin
               b.kind = 1'($urandom);
               b.index = INDEX_W'($urandom);
               b.first = 1'($urandom);
            end
            send_beat(b);
            rest(random_gap());
         end
      repeat ($urandom_range(1, 3)) begin
         d = base - int'($urandom_range(0, 3));
         if (d < 0 || $urandom_range(7) == 0) d = int'($urandom_range(0, 1023));
         send_beat(query_at(d));
         rest(random_gap());
      end
   endtask

   // Random ensembles under a series of register settings; windows are short
   // in most phases so that queries stay cheap, with one wide-window phase.
   task automatic test_random_traffic();
      int count, window, mute, stop;
      for (int phase = 0; phase < 7; phase++) begin
         count = (phase % 3 == 0) ? 1024 : int'($urandom_range(1, 1100));
         window = (phase == 6) ? 1024 : int'($urandom_range(1, 24));
         mute = ($urandom_range(2) == 0) ? int'($urandom_range(0, count / 4)) : 0;
         set_registers(count, window, mute, phase == 3);
         stop = beats_sent + ((phase == 6) ? 120 : 280);
         while (beats_sent < stop) run_ensemble();
         settle();
      end
   endtask

   // Every result beat must match the oldest expectation, field by field.
   always @(posedge clock) begin
      coherence_type e;
      if (!reset && rsp_valid) begin
         if (coherence_due.size() == 0) begin
            $error("result beat with no query outstanding");
            fail_count++;
         end else begin
            e = coherence_due.pop_front();
            if (rsp_coherence_x !== e.coh[0]) begin
               $error("coherence_x expected %0d actual %0d", e.coh[0], rsp_coherence_x);
               fail_count++;
            end
            if (rsp_coherence_y !== e.coh[1]) begin
               $error("coherence_y expected %0d actual %0d", e.coh[1], rsp_coherence_y);
               fail_count++;
            end
            if (rsp_coherence_z !== e.coh[2]) begin
               $error("coherence_z expected %0d actual %0d", e.coh[2], rsp_coherence_z);
               fail_count++;
            end
            if (rsp_coherence_total !== e.coh[3]) begin
               $error("coherence_total expected %0d actual %0d", e.coh[3],
                      rsp_coherence_total);
               fail_count++;
            end
            if (rsp_samples_used !== e.used) begin
               $error("samples_used expected %0d actual %0d", e.used, rsp_samples_used);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_extremes();
      test_random_traffic();
      settle();
      repeat (64) @(posedge clock);
      if (coherence_due.size() != 0) begin
         $error("%0d expected results never arrived", coherence_due.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Hard stop well beyond the slowest correct run.
   initial begin
      #40000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
rtl/wsc_pkg.sv
rtl/wsc_coh.sv
rtl/wsc_lane.sv
rtl/weighted_stack_coherence.sv
tb/sv/tb.sv
